@@ sv/bksl_pkg.sv @@
`default_nettype none
package bksl_pkg;

	localparam int KEY_W   = 64;
	localparam int ENTRY_W = 2 * KEY_W;

	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_LIST   = 3'd1;
	localparam logic [2:0] CMD_FIND   = 3'd2;
	localparam logic [2:0] CMD_POP    = 3'd3;
	localparam logic [2:0] CMD_INSERT = 3'd4;
	localparam logic [2:0] CMD_TAKE   = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] payload;
	} entry_t;

endpackage
`default_nettype wire

@@ sv/bounded_keyed_stack_list.sv @@
`default_nettype none
// Ordered list of up to DEPTH key/payload entries, position 1 at the bottom, driven one
// command item at a time: push, list (top first), find (ascending), pop, insert at a
// position and take the highest entry matching a key. Every command ends with a result
// item flagged last; list and find give one result per reported entry. The entries sit
// in a single RAM with one registered read port, and a small sequencer walks it one
// entry per step, so the count of entries sets the time of list, find, take and insert;
// insert moves each entry from its position up one place, and take moves each entry above
// the one it removes down one place. A new command is taken once the last result of the
// previous one is in the output register, even while that result waits on res_stall.
// The RAM needs no clearing after reset; only the entries below the count are read.
module bounded_keyed_stack_list #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [2:0]  command,
	input  wire logic [4:0]  position,
	input  wire logic [63:0] key_in,
	input  wire logic [63:0] payload_in,

	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       status,
	output logic [4:0]       entry_position,
	output logic [63:0]      key_out,
	output logic [63:0]      payload_out,
	output logic [4:0]       entry_count,
	output logic             last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW + 1 > 5) ? CW + 1 : 5;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_EVAL = 4'd3;
	localparam logic [3:0] S_EMIT = 4'd4;
	localparam logic [3:0] S_FEND = 4'd5;
	localparam logic [3:0] S_TEND = 4'd6;
	localparam logic [3:0] S_SRD  = 4'd7;
	localparam logic [3:0] S_SWR  = 4'd8;
	localparam logic [3:0] S_URD  = 4'd9;
	localparam logic [3:0] S_UWR  = 4'd10;
	localparam logic [3:0] S_IWR  = 4'd11;

	function automatic logic [4:0] to_pos(input logic [CW-1:0] v);
		logic [PW-1:0] w;
		w = PW'(v);
		return w[4:0];
	endfunction

	// control state
	logic [3:0]    state_q, state_d, ret_q, ret_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          held_q, held_d;
	logic [CW-1:0] hit_q, hit_d;
	logic          res_valid_q, res_valid_d;

	// payload registers
	logic [2:0]    cmd_q, cmd_d;
	logic [4:0]    pos_q, pos_d;
	logic [63:0]   key_q, key_d;
	logic [63:0]   pay_q, pay_d;
	logic [CW-1:0] hold_pos_q, hold_pos_d;
	logic [63:0]   hold_pay_q, hold_pay_d;
	logic [63:0]   hit_pay_q, hit_pay_d;
	logic [2:0]    em_status_q, em_status_d;
	logic [4:0]    em_pos_q, em_pos_d;
	logic [63:0]   em_key_q, em_key_d;
	logic [63:0]   em_pay_q, em_pay_d;
	logic          em_last_q, em_last_d;
	logic [2:0]    status_q, status_d;
	logic [4:0]    entry_position_q, entry_position_d;
	logic [63:0]   key_out_q, key_out_d;
	logic [63:0]   payload_out_q, payload_out_d;
	logic [4:0]    entry_count_q, entry_count_d;
	logic          last_q, last_d;

	// memory port
	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [bksl_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
	bksl_pkg::entry_t             rd_ent, new_ent;

	logic          slot_free, is_full, is_empty, bad_pos, match, scan_end;
	logic [CW-1:0] idx_m1, count_p1, count_m1;
	logic [PW-1:0] pos_m1, pos_ext;

	assign rd_ent   = ram_rdata;
	assign new_ent  = '{key: key_q, payload: pay_q};
	assign idx_m1   = idx_q - 1'b1;
	assign count_p1 = count_q + 1'b1;
	assign count_m1 = count_q - 1'b1;
	assign pos_ext  = PW'(pos_q);
	assign pos_m1   = pos_ext - 1'b1;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign bad_pos  = (pos_ext == '0) || (pos_ext > PW'(count_p1));
	assign match    = (rd_ent.key == key_q);
	assign scan_end = (idx_q == count_q);
	assign slot_free = !res_valid_q || !res_stall;

	assign cmd_stall = (state_q != S_IDLE);

	bksl_ram #(
		.WIDTH(bksl_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d          = state_q;
		ret_d            = ret_q;
		count_d          = count_q;
		idx_d            = idx_q;
		held_d           = held_q;
		hit_d            = hit_q;
		res_valid_d      = res_valid_q;
		cmd_d            = cmd_q;
		pos_d            = pos_q;
		key_d            = key_q;
		pay_d            = pay_q;
		hold_pos_d       = hold_pos_q;
		hold_pay_d       = hold_pay_q;
		hit_pay_d        = hit_pay_q;
		em_status_d      = em_status_q;
		em_pos_d         = em_pos_q;
		em_key_d         = em_key_q;
		em_pay_d         = em_pay_q;
		em_last_d        = em_last_q;
		status_d         = status_q;
		entry_position_d = entry_position_q;
		key_out_d        = key_out_q;
		payload_out_d    = payload_out_q;
		entry_count_d    = entry_count_q;
		last_d           = last_q;
		ram_we           = 1'b0;
		ram_waddr        = idx_m1[AW-1:0];
		ram_wdata        = ram_rdata;
		ram_re           = 1'b0;
		ram_raddr        = idx_m1[AW-1:0];

		if (res_valid_q && !res_stall) begin
			res_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_d   = command;
					pos_d   = position;
					key_d   = key_in;
					pay_d   = payload_in;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				// error or no-entry result unless a branch below says otherwise
				em_status_d = bksl_pkg::ST_EMPTY;
				em_pos_d    = '0;
				em_key_d    = '0;
				em_pay_d    = '0;
				em_last_d   = 1'b1;
				ret_d       = S_IDLE;
				state_d     = S_EMIT;
				case (cmd_q)
					bksl_pkg::CMD_PUSH: begin
						if (is_full) begin
							em_status_d = bksl_pkg::ST_FULL;
						end else begin
							ram_we      = 1'b1;
							ram_waddr   = count_q[AW-1:0];
							ram_wdata   = new_ent;
							count_d     = count_p1;
							em_status_d = bksl_pkg::ST_OK;
							em_pos_d    = to_pos(count_p1);
							em_key_d    = key_q;
							em_pay_d    = pay_q;
						end
					end
					bksl_pkg::CMD_LIST, bksl_pkg::CMD_POP: begin
						if (!is_empty) begin
							idx_d   = count_q;
							state_d = S_RD;
						end
					end
					bksl_pkg::CMD_FIND, bksl_pkg::CMD_TAKE: begin
						if (!is_empty) begin
							idx_d   = CW'(1);
							held_d  = 1'b0;
							hit_d   = '0;
							state_d = S_RD;
						end
					end
					bksl_pkg::CMD_INSERT: begin
						if (is_empty) begin
							em_status_d = bksl_pkg::ST_EMPTY;
						end else if (is_full) begin
							em_status_d = bksl_pkg::ST_FULL;
						end else if (bad_pos) begin
							em_status_d = bksl_pkg::ST_BADPOS;
						end else begin
							em_status_d = bksl_pkg::ST_OK;
							em_pos_d    = pos_q;
							em_key_d    = key_q;
							em_pay_d    = pay_q;
							idx_d       = count_q;
							// insert on top moves nothing
							state_d     = (pos_ext == PW'(count_p1)) ? S_IWR : S_URD;
						end
					end
					default: begin
						em_status_d = bksl_pkg::ST_OK;
					end
				endcase
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				case (cmd_q)
					bksl_pkg::CMD_LIST: begin
						em_status_d = bksl_pkg::ST_OK;
						em_pos_d    = to_pos(idx_q);
						em_key_d    = rd_ent.key;
						em_pay_d    = rd_ent.payload;
						em_last_d   = (idx_q == CW'(1));
						ret_d       = (idx_q == CW'(1)) ? S_IDLE : S_RD;
						idx_d       = idx_m1;
						state_d     = S_EMIT;
					end
					bksl_pkg::CMD_POP: begin
						em_status_d = bksl_pkg::ST_OK;
						em_pos_d    = to_pos(idx_q);
						em_key_d    = rd_ent.key;
						em_pay_d    = rd_ent.payload;
						em_last_d   = 1'b1;
						count_d     = count_m1;
						ret_d       = S_IDLE;
						state_d     = S_EMIT;
					end
					bksl_pkg::CMD_FIND: begin
						if (!scan_end) begin
							idx_d = idx_q + 1'b1;
						end
						state_d = scan_end ? S_FEND : S_RD;
						if (match) begin
							// hold one match back so the final one can carry last
							held_d     = 1'b1;
							hold_pos_d = idx_q;
							hold_pay_d = rd_ent.payload;
							if (held_q) begin
								em_status_d = bksl_pkg::ST_OK;
								em_pos_d    = to_pos(hold_pos_q);
								em_key_d    = key_q;
								em_pay_d    = hold_pay_q;
								em_last_d   = 1'b0;
								ret_d       = scan_end ? S_FEND : S_RD;
								state_d     = S_EMIT;
							end
						end
					end
					bksl_pkg::CMD_TAKE: begin
						if (match) begin
							hit_d     = idx_q;
							hit_pay_d = rd_ent.payload;
						end
						if (!scan_end) begin
							idx_d = idx_q + 1'b1;
						end
						state_d = scan_end ? S_TEND : S_RD;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_FEND: begin
				em_last_d = 1'b1;
				ret_d     = S_IDLE;
				state_d   = S_EMIT;
				if (held_q) begin
					em_status_d = bksl_pkg::ST_OK;
					em_pos_d    = to_pos(hold_pos_q);
					em_key_d    = key_q;
					em_pay_d    = hold_pay_q;
				end else begin
					em_status_d = bksl_pkg::ST_NOTFOUND;
					em_pos_d    = '0;
					em_key_d    = '0;
					em_pay_d    = '0;
				end
			end
			S_TEND: begin
				em_last_d = 1'b1;
				ret_d     = S_IDLE;
				state_d   = S_EMIT;
				if (hit_q == '0) begin
					em_status_d = bksl_pkg::ST_NOTFOUND;
					em_pos_d    = '0;
					em_key_d    = '0;
					em_pay_d    = '0;
				end else begin
					em_status_d = bksl_pkg::ST_OK;
					em_pos_d    = to_pos(hit_q);
					em_key_d    = key_q;
					em_pay_d    = hit_pay_q;
					if (hit_q == count_q) begin
						count_d = count_m1;
					end else begin
						idx_d   = hit_q;
						state_d = S_SRD;
					end
				end
			end
			S_SRD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[AW-1:0];
				state_d   = S_SWR;
			end
			S_SWR: begin
				// close down: entry above moves one place lower
				ram_we    = 1'b1;
				ram_waddr = idx_m1[AW-1:0];
				if (idx_q == count_m1) begin
					count_d = count_m1;
					state_d = S_EMIT;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_SRD;
				end
			end
			S_URD: begin
				ram_re  = 1'b1;
				state_d = S_UWR;
			end
			S_UWR: begin
				// open a gap: entry moves one place higher
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				if (PW'(idx_q) == pos_ext) begin
					state_d = S_IWR;
				end else begin
					idx_d   = idx_m1;
					state_d = S_URD;
				end
			end
			S_IWR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_m1[AW-1:0];
				ram_wdata = new_ent;
				count_d   = count_p1;
				ret_d     = S_IDLE;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					res_valid_d      = 1'b1;
					status_d         = em_status_q;
					entry_position_d = em_pos_q;
					key_out_d        = em_key_q;
					payload_out_d    = em_pay_q;
					entry_count_d    = to_pos(count_q);
					last_d           = em_last_q;
					state_d          = ret_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			held_q      <= 1'b0;
			hit_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			held_q      <= held_d;
			hit_q       <= hit_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q            <= cmd_d;
		pos_q            <= pos_d;
		key_q            <= key_d;
		pay_q            <= pay_d;
		hold_pos_q       <= hold_pos_d;
		hold_pay_q       <= hold_pay_d;
		hit_pay_q        <= hit_pay_d;
		em_status_q      <= em_status_d;
		em_pos_q         <= em_pos_d;
		em_key_q         <= em_key_d;
		em_pay_q         <= em_pay_d;
		em_last_q        <= em_last_d;
		status_q         <= status_d;
		entry_position_q <= entry_position_d;
		key_out_q        <= key_out_d;
		payload_out_q    <= payload_out_d;
		entry_count_q    <= entry_count_d;
		last_q           <= last_d;
	end

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign entry_position = entry_position_q;
	assign key_out        = key_out_q;
	assign payload_out    = payload_out_q;
	assign entry_count    = entry_count_q;
	assign last           = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command taken while previous one still running");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("store written while idle");

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != bksl_pkg::ST_OK) |-> (last && entry_position == '0))
		else $error("error result not final or carries an entry");

endmodule
`default_nettype wire

@@ sv/bksl_ram.sv @@
`default_nettype none
module bksl_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire
